>>> rtl/core/pdmc_pkg.sv
// Package for the protease digest / missed cleavage unit.
// Holds payload structs, controller/datapath command and status types,
// register codes and reset values. No dependencies.
`timescale 1ns / 1ps

package pdmc_pkg;

  localparam int unsigned MaxMissedDefault     = 4;
  localparam int unsigned MaxProteinLenDefault = 65536;

  localparam int unsigned ResW     = 8;
  localparam int unsigned ProtIdW  = 20;
  localparam int unsigned PosOutW  = 16;
  localparam int unsigned MissW    = 3;
  localparam int unsigned MaskW    = 26;
  localparam int unsigned LenW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 26;

  localparam logic [ResW-1:0] CharA = 8'h41;
  localparam logic [ResW-1:0] CharZ = 8'h5A;
  localparam logic [ResW-1:0] CharM = 8'h4D;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgCleaveAfter = 3'd0,
    CfgNotBefore   = 3'd1,
    CfgMaxMissed   = 3'd2,
    CfgMinLength   = 3'd3,
    CfgMaxLength   = 3'd4
  } cfg_idx_e;

  localparam logic [MaskW-1:0] CleaveAfterRst = 26'h0020400;  // K, R
  localparam logic [MaskW-1:0] NotBeforeRst   = 26'h0008000;  // P
  localparam logic [MissW-1:0] MaxMissedRst   = 3'd0;
  localparam logic [LenW-1:0]  MinLengthRst   = 8'd5;
  localparam logic [LenW-1:0]  MaxLengthRst   = 8'd60;

  typedef struct packed {
    logic [ResW-1:0]    residue;
    logic               last_residue;
    logic [ProtIdW-1:0] protein_id;
    logic               decoy_flag;
    logic               contaminant_flag;
  } in_t;

  typedef struct packed {
    logic [PosOutW-1:0] peptide_start;
    logic [PosOutW-1:0] peptide_end;
    logic [MissW-1:0]   missed_count;
    logic [ProtIdW-1:0] out_protein_id;
    logic               out_decoy;
    logic               out_contaminant;
    logic               run_last;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // take the input transaction
    logic push_first;   // first residue: clear starts, push position
    logic push_site;    // push position after a site group
    logic scan_load;    // restart start scan
    logic end_sel_pos;  // scan end is current position (protein end)
    logic scan_step;    // check one start, keep it if the length fits
    logic flush;        // retire pending result, update residue state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_prev;
    logic last;
    logic site;
    logic in_range;
    logic hit;
    logic out_free;
    logic pend_valid;
  } sts_t;

  function automatic logic letter_hit(logic [MaskW-1:0] mask, logic [ResW-1:0] c);
    logic [ResW-1:0] off;
    off = c - CharA;
    return (c >= CharA && c <= CharZ) ? mask[off[4:0]] : 1'b0;
  endfunction

endpackage

>>> rtl/core/pdmc_ctrl.sv
// Controller for the protease digest unit: sequences one residue through
// site test, start scans and result retirement. Uses pdmc_pkg.
`timescale 1ns / 1ps

module pdmc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  pdmc_pkg::sts_t  sts_i,
  output logic            in_stall_o,
  output pdmc_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEval  = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0] state_q, state_d;
  logic       phase_q, phase_d;  // 0: site group, 1: protein end group

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StEval;
        end
      end
      StEval: begin
        priority if (!sts_i.have_prev) begin
          cmd_o.push_first = 1'b1;
          if (sts_i.last) begin
            cmd_o.scan_load   = 1'b1;
            cmd_o.end_sel_pos = 1'b1;
            phase_d           = 1'b1;
            state_d           = StScan;
          end else begin
            state_d = StFlush;
          end
        end else if (sts_i.site) begin
          cmd_o.scan_load = 1'b1;
          phase_d         = 1'b0;
          state_d         = StScan;
        end else if (sts_i.last) begin
          cmd_o.scan_load   = 1'b1;
          cmd_o.end_sel_pos = 1'b1;
          phase_d           = 1'b1;
          state_d           = StScan;
        end else begin
          state_d = StFlush;
        end
      end
      StScan: begin
        if (sts_i.in_range) begin
          // a hit displaces the pending result into the output register
          if (!sts_i.hit || !sts_i.pend_valid || sts_i.out_free) begin
            cmd_o.scan_step = 1'b1;
          end
        end else if (!phase_q) begin
          cmd_o.push_site = 1'b1;
          if (sts_i.last) begin
            cmd_o.scan_load   = 1'b1;
            cmd_o.end_sel_pos = 1'b1;
            phase_d           = 1'b1;
          end else begin
            state_d = StFlush;
          end
        end else begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

>>> rtl/core/pdmc_dp.sv
// Datapath for the protease digest unit: config registers, residue state,
// start ring, length check, pending result and output register. Uses pdmc_pkg.
`timescale 1ns / 1ps

module pdmc_dp #(
  parameter int unsigned MAX_MISSED      = pdmc_pkg::MaxMissedDefault,
  parameter int unsigned MAX_PROTEIN_LEN = pdmc_pkg::MaxProteinLenDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdmc_pkg::in_t                   in_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output pdmc_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pdmc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pdmc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  pdmc_pkg::cmd_t                  cmd_i,
  output pdmc_pkg::sts_t                  sts_o
);

  localparam int unsigned Depth = MAX_MISSED + 1;
  localparam int unsigned PosW  = $clog2(MAX_PROTEIN_LEN);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CmpW  = (CntW > pdmc_pkg::MissW) ? CntW : pdmc_pkg::MissW;
  localparam int unsigned LcW   = (PosW + 1 > pdmc_pkg::LenW) ? PosW + 1 : pdmc_pkg::LenW;
  localparam int unsigned MmCap = (MAX_MISSED > 7) ? 7 : MAX_MISSED;
  localparam logic [PosW-1:0] PosLast = PosW'(MAX_PROTEIN_LEN - 1);
  localparam logic [PosW:0]   PosSpan = (PosW + 1)'(MAX_PROTEIN_LEN);

  // configuration
  logic [pdmc_pkg::MaskW-1:0] cleave_q, not_before_q;
  logic [pdmc_pkg::MissW-1:0] max_missed_q;
  logic [pdmc_pkg::LenW-1:0]  min_len_q, max_len_q;

  // residue state
  logic [PosW-1:0]           pos_q;
  logic [pdmc_pkg::ResW-1:0] prev_q;
  logic                      have_prev_q;
  logic [PosW-1:0]           ring_q [Depth];
  logic [CntW-1:0]           cnt_q;

  // current transaction and scan
  pdmc_pkg::in_t   item_q;
  logic [PosW-1:0] end_q;
  logic [CntW-1:0] m_q;

  pdmc_pkg::out_t pend_q, out_q, cand, retire;
  logic           pend_valid_q, out_valid_q;

  logic [PosW-1:0]            prev_pos, start_pos;
  logic [pdmc_pkg::MissW-1:0] mm;
  logic [PosW:0]              diff, len;
  logic                       in_range, hit, out_free, move_out;

  assign prev_pos  = (pos_q == '0) ? PosLast : pos_q - PosW'(1);
  assign mm        = (max_missed_q > pdmc_pkg::MissW'(MmCap)) ?
                     pdmc_pkg::MissW'(MmCap) : max_missed_q;
  assign start_pos = ring_q[m_q[IdxW-1:0]];

  // length with wrap, modulo the protein length
  always_comb begin
    diff = {1'b0, end_q} - {1'b0, start_pos};
    if (diff[PosW]) begin
      diff = diff + PosSpan;
    end
    len = diff + (PosW + 1)'(1);
  end

  assign in_range = (CmpW'(m_q) <= CmpW'(mm)) && (m_q < cnt_q);
  assign hit      = (LcW'(len) > LcW'(min_len_q)) && (LcW'(len) <= LcW'(max_len_q));
  assign out_free = !out_valid_q || !out_stall_i;
  assign move_out = pend_valid_q && ((cmd_i.scan_step && hit) || cmd_i.flush);

  always_comb begin
    cand                 = '0;
    cand.peptide_start   = pdmc_pkg::PosOutW'(start_pos);
    cand.peptide_end     = pdmc_pkg::PosOutW'(end_q);
    cand.missed_count    = pdmc_pkg::MissW'(m_q);
    cand.out_protein_id  = item_q.protein_id;
    cand.out_decoy       = item_q.decoy_flag;
    cand.out_contaminant = item_q.contaminant_flag;
    cand.run_last        = 1'b0;
  end

  // the pending result is the last of its residue when it leaves on flush
  always_comb begin
    retire          = pend_q;
    retire.run_last = cmd_i.flush;
  end

  always_comb begin
    sts_o            = '0;
    sts_o.have_prev  = have_prev_q;
    sts_o.last       = item_q.last_residue;
    // initiator M at position 0 never cuts
    sts_o.site       = pdmc_pkg::letter_hit(cleave_q, prev_q) &&
                       !pdmc_pkg::letter_hit(not_before_q, item_q.residue) &&
                       !(prev_pos == '0 && prev_q == pdmc_pkg::CharM);
    sts_o.in_range   = in_range;
    sts_o.hit        = hit;
    sts_o.out_free   = out_free;
    sts_o.pend_valid = pend_valid_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cleave_q     <= pdmc_pkg::CleaveAfterRst;
      not_before_q <= pdmc_pkg::NotBeforeRst;
      max_missed_q <= pdmc_pkg::MaxMissedRst;
      min_len_q    <= pdmc_pkg::MinLengthRst;
      max_len_q    <= pdmc_pkg::MaxLengthRst;
      pos_q        <= '0;
      prev_q       <= '0;
      have_prev_q  <= 1'b0;
      cnt_q        <= '0;
      m_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (pdmc_pkg::cfg_idx_e'(cfg_index_i))
          pdmc_pkg::CfgCleaveAfter: cleave_q     <= cfg_data_i;
          pdmc_pkg::CfgNotBefore:   not_before_q <= cfg_data_i;
          pdmc_pkg::CfgMaxMissed:   max_missed_q <= cfg_data_i[pdmc_pkg::MissW-1:0];
          pdmc_pkg::CfgMinLength:   min_len_q    <= cfg_data_i[pdmc_pkg::LenW-1:0];
          pdmc_pkg::CfgMaxLength:   max_len_q    <= cfg_data_i[pdmc_pkg::LenW-1:0];
          default: ;
        endcase
      end

      if (cmd_i.push_first) begin
        cnt_q <= CntW'(1);
      end else if (cmd_i.push_site && cnt_q < CntW'(Depth)) begin
        cnt_q <= cnt_q + CntW'(1);
      end

      if (cmd_i.scan_load) begin
        m_q <= '0;
      end else if (cmd_i.scan_step) begin
        m_q <= m_q + CntW'(1);
      end

      if (cmd_i.flush) begin
        pend_valid_q <= 1'b0;
        if (item_q.last_residue) begin
          pos_q       <= '0;
          prev_q      <= '0;
          have_prev_q <= 1'b0;
          cnt_q       <= '0;
        end else begin
          prev_q      <= item_q.residue;
          have_prev_q <= 1'b1;
          pos_q       <= (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
        end
      end else if (cmd_i.scan_step && hit) begin
        pend_valid_q <= 1'b1;
      end

      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.scan_load) begin
      end_q <= cmd_i.end_sel_pos ? pos_q : prev_pos;
    end
    if (cmd_i.push_first || cmd_i.push_site) begin
      for (int i = Depth - 1; i > 0; i--) begin
        ring_q[i] <= ring_q[i-1];
      end
      ring_q[0] <= pos_q;
    end
    if (cmd_i.scan_step && hit) begin
      pend_q <= cand;
    end
    if (move_out) begin
      out_q <= retire;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/protease_digest_missed_cleavage_unit.sv
// Top level of the protease digest / missed cleavage unit.
// Instantiates pdmc_ctrl and pdmc_dp; types from pdmc_pkg.
`timescale 1ns / 1ps

// Takes one residue per input transaction and emits the peptides that end
// at each cleavage site, shortest missed count first, with run_last on the
// final peptide a residue causes. A residue is evaluated first; each peptide
// group that it closes then scans the stored starts, shortest first (up to
// max_missed + 1), and a flush retires the pending result; a last residue
// that also ends a site runs two groups. The start ring is scanned through
// one length check, and a waiting peptide must leave the single output
// register before the next accepted one can move up. A result waits in the
// output register while the next residue is accepted.
module protease_digest_missed_cleavage_unit #(
  parameter int unsigned MAX_MISSED      = pdmc_pkg::MaxMissedDefault,
  parameter int unsigned MAX_PROTEIN_LEN = pdmc_pkg::MaxProteinLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pdmc_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pdmc_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pdmc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pdmc_pkg::CfgDataW-1:0] cfg_data_i
);

  pdmc_pkg::cmd_t cmd;
  pdmc_pkg::sts_t sts;

  pdmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  pdmc_dp #(
    .MAX_MISSED      (MAX_MISSED),
    .MAX_PROTEIN_LEN (MAX_PROTEIN_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> rtl/core/pdmc_chk.sv
// Port-level checker for protease_digest_missed_cleavage_unit, bound to it.
// Uses pdmc_pkg types.
`timescale 1ns / 1ps

module pdmc_chk #(
  parameter int unsigned MAX_MISSED = pdmc_pkg::MaxMissedDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input pdmc_pkg::out_t                out_data_o
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // a residue is evaluated before the next one is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  // missed count stays within the ring depth
  a_missed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(out_data_o.missed_count) <= int'(MAX_MISSED)))
    else $error("missed count beyond start ring depth");

endmodule

bind protease_digest_missed_cleavage_unit pdmc_chk #(
  .MAX_MISSED (MAX_MISSED)
) u_pdmc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> tb/testbench.sv
// Self-checking testbench for protease_digest_missed_cleavage_unit.
// Streams proteins through the unit, predicts every peptide in step with the
// input handshake, and checks results in order. Needs pdmc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import pdmc_pkg::*;

  localparam int CycleLimit  = 1200000;
  localparam int DrainCycles = 40;
  localparam int RingDepth   = 5;

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallBursty,
    StallToggle
  } stall_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  protease_digest_missed_cleavage_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow copy of the unit's registers and digest state
  logic [MaskW-1:0] cut_mask   = CleaveAfterRst;
  logic [MaskW-1:0] block_mask = NotBeforeRst;
  logic [MissW-1:0] miss_lim   = MaxMissedRst;
  logic [LenW-1:0]  min_len    = MinLengthRst;
  logic [LenW-1:0]  max_len    = MaxLengthRst;

  logic [15:0] cur_pos   = '0;
  logic [7:0]  prev_res  = '0;
  bit          have_prev = 1'b0;
  logic [15:0] starts [RingDepth];
  int          n_starts  = 0;

  in_t  residue_q [$];
  out_t peptide_q [$];
  int   errors = 0;
  int   cycles = 0;

  // sender burst control
  int burst_left = 8;
  int gap_left   = 0;

  // receiver stall pattern
  stall_mode_e stall_mode = StallNone;
  int          mode_left  = 0;
  int          run_left   = 0;

  function automatic bit letter_set(logic [MaskW-1:0] mask, logic [7:0] c);
    if (c < CharA || c > CharZ) return 1'b0;
    return mask[c - CharA];
  endfunction

  task automatic push_start(logic [15:0] pos);
    for (int i = RingDepth - 1; i > 0; i--) starts[i] = starts[i-1];
    starts[0] = pos;
    if (n_starts < RingDepth) n_starts++;
  endtask

  // peptides ending at end_pos, fewest missed sites first
  task automatic close_group(logic [15:0] end_pos, in_t item, ref out_t grp[$]);
    int          lim;
    logic [16:0] len;
    out_t        pep;
    lim = (miss_lim > 3'd4) ? 4 : int'(miss_lim);
    for (int m = 0; m <= lim && m < n_starts; m++) begin
      len = {1'b0, 16'(end_pos - starts[m])} + 17'd1;
      if (len > {9'd0, min_len} && len <= {9'd0, max_len}) begin
        pep.peptide_start   = starts[m];
        pep.peptide_end     = end_pos;
        pep.missed_count    = MissW'(m);
        pep.out_protein_id  = item.protein_id;
        pep.out_decoy       = item.decoy_flag;
        pep.out_contaminant = item.contaminant_flag;
        pep.run_last        = 1'b0;
        grp.push_back(pep);
      end
    end
  endtask

  task automatic digest_residue(in_t item);
    out_t        grp [$];
    logic [15:0] prev_pos;
    bit          site;
    if (!have_prev) begin
      n_starts = 0;
      push_start(cur_pos);
    end else begin
      prev_pos = cur_pos - 16'd1;
      // the decision on a residue waits for its successor
      site = letter_set(cut_mask, prev_res) && !letter_set(block_mask, item.residue) &&
             !(prev_pos == 16'd0 && prev_res == CharM);
      if (site) begin
        close_group(prev_pos, item, grp);
        push_start(cur_pos);
      end
    end
    if (item.last_residue) begin
      close_group(cur_pos, item, grp);
      cur_pos   = '0;
      prev_res  = '0;
      have_prev = 1'b0;
      n_starts  = 0;
    end else begin
      prev_res  = item.residue;
      have_prev = 1'b1;
      cur_pos   = cur_pos + 16'd1;
    end
    if (grp.size() > 0) grp[grp.size()-1].run_last = 1'b1;
    foreach (grp[i]) peptide_q.push_back(grp[i]);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk_i) begin : drv
    bit hold;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        digest_residue(in_data_i);
        void'(residue_q.pop_front());
      end
      hold = in_valid_i && in_stall_o;
      if (!hold) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (residue_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= residue_q[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 12);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : rcv
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      StallNone:   out_stall_i <= 1'b0;
      StallRandom: out_stall_i <= ($urandom_range(0, 9) < 3);
      StallBursty: begin
        if (run_left > 0) begin
          run_left--;
        end else begin
          out_stall_i <= ~out_stall_i;
          run_left = $urandom_range(1, 20);
        end
      end
      default:     out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin : mon
    out_t exp_pep;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (peptide_q.size() == 0) begin
        $error("peptide %0h..%0h with nothing expected",
               out_data_o.peptide_start, out_data_o.peptide_end);
        errors++;
      end else begin
        exp_pep = peptide_q.pop_front();
        check_field("peptide_start", 32'(exp_pep.peptide_start),
                    32'(out_data_o.peptide_start));
        check_field("peptide_end", 32'(exp_pep.peptide_end), 32'(out_data_o.peptide_end));
        check_field("missed_count", 32'(exp_pep.missed_count),
                    32'(out_data_o.missed_count));
        check_field("out_protein_id", 32'(exp_pep.out_protein_id),
                    32'(out_data_o.out_protein_id));
        check_field("out_decoy", 32'(exp_pep.out_decoy), 32'(out_data_o.out_decoy));
        check_field("out_contaminant", 32'(exp_pep.out_contaminant),
                    32'(out_data_o.out_contaminant));
        check_field("run_last", 32'(exp_pep.run_last), 32'(out_data_o.run_last));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("protease_digest_missed_cleavage_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CfgCleaveAfter: cut_mask   = val[MaskW-1:0];
      CfgNotBefore:   block_mask = val[MaskW-1:0];
      CfgMaxMissed:   miss_lim   = val[MissW-1:0];
      CfgMinLength:   min_len    = val[LenW-1:0];
      CfgMaxLength:   max_len    = val[LenW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [MaskW-1:0] cut, logic [MaskW-1:0] blk, logic [MissW-1:0] mm,
                           logic [LenW-1:0] mn, logic [LenW-1:0] mx);
    write_reg(CfgCleaveAfter, CfgDataW'(cut));
    write_reg(CfgNotBefore, CfgDataW'(blk));
    write_reg(CfgMaxMissed, CfgDataW'(mm));
    write_reg(CfgMinLength, CfgDataW'(mn));
    write_reg(CfgMaxLength, CfgDataW'(mx));
  endtask

  // all residues taken, all peptides seen, then let the unit go quiet
  task automatic settle();
    while (residue_q.size() != 0 || peptide_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_item(logic [7:0] c, bit last, logic [ProtIdW-1:0] id, bit dec, bit con);
    in_t item;
    item.residue          = c;
    item.last_residue     = last;
    item.protein_id       = id;
    item.decoy_flag       = dec;
    item.contaminant_flag = con;
    residue_q.push_back(item);
  endtask

  task automatic add_seq(string s, logic [ProtIdW-1:0] id, bit dec, bit con);
    for (int i = 0; i < s.len(); i++) add_item(s[i], i == s.len() - 1, id, dec, con);
  endtask

  function automatic logic [7:0] masked_letter(logic [MaskW-1:0] mask);
    int k;
    k = $urandom_range(0, 25);
    for (int t = 0; t < 8 && !mask[k]; t++) k = $urandom_range(0, 25);
    return CharA + 8'(k);
  endfunction

  function automatic logic [7:0] pick_residue();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return masked_letter(cut_mask);
    if (r < 35) return masked_letter(block_mask);
    if (r < 40) return CharM;
    if (r < 88) return CharA + 8'($urandom_range(0, 25));
    if (r < 96) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  task automatic add_protein(int len);
    logic [ProtIdW-1:0] id;
    bit                 dec, con, vary;
    id   = ProtIdW'($urandom);
    dec  = 1'($urandom_range(0, 1));
    con  = 1'($urandom_range(0, 1));
    vary = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if (vary) begin
        id  = ProtIdW'($urandom);
        dec = 1'($urandom_range(0, 1));
        con = 1'($urandom_range(0, 1));
      end
      add_item(pick_residue(), i == len - 1, id, dec, con);
    end
  endtask

  task automatic run_random(int target);
    int added, r, len;
    added = 0;
    while (added < target) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 80) len = $urandom_range(2, 20);
      else len = $urandom_range(21, 70);
      add_protein(len);
      added += len;
    end
    settle();
  endtask

  initial begin : main
    logic [LenW-1:0] mn;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one K site long enough to pass, short protein end
    add_seq("AAAAAAKW", 20'h00001, 1'b0, 1'b0);
    settle();

    // directed: M initiator, KP block, non-letters, single residue, full ring
    configure(26'h0021400, NotBeforeRst, 3'd7, 8'd0, 8'd255);
    add_seq("MKPRMKRK", 20'hFFFFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b0, 20'h00000, 1'b0, 1'b0);
    add_item(8'h40, 1'b0, 20'h00000, 1'b0, 1'b0);
    add_item(8'h5B, 1'b0, 20'h00000, 1'b0, 1'b0);
    add_item(8'hFF, 1'b0, 20'h00000, 1'b0, 1'b0);
    add_item(8'h6B, 1'b0, 20'h00000, 1'b0, 1'b0);
    add_item(CharZ, 1'b1, 20'h00000, 1'b0, 1'b0);
    add_seq("K", 20'h12345, 1'b0, 1'b1);
    add_seq("RRRRR", 20'h3C3C3, 1'b1, 1'b0);
    settle();

    configure(CleaveAfterRst, NotBeforeRst, 3'd2, 8'd0, 8'd255);
    run_random(25);
    configure(26'h3FFFFFF, 26'h0000000, 3'd4, 8'd1, 8'd8);
    run_random(25);
    configure(26'h0000000, 26'h3FFFFFF, 3'd1, 8'd0, 8'd1);
    run_random(25);
    mn = LenW'($urandom_range(0, 6));
    configure(MaskW'($urandom), MaskW'($urandom & $urandom & $urandom),
              MissW'($urandom_range(0, 7)), mn, LenW'($urandom_range(7, 80)));
    run_random(25);
    configure(26'h3FFFFFF, 26'h3FFFFFF, 3'd7, 8'd255, 8'd255);
    run_random(25);
    mn = LenW'($urandom_range(0, 4));
    configure(MaskW'($urandom & $urandom), MaskW'($urandom & $urandom),
              MissW'($urandom_range(0, 7)), mn, LenW'($urandom_range(5, 40)));
    run_random(25);

    if (peptide_q.size() != 0) begin
      $error("%0d expected peptides never arrived", peptide_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("protease_digest_missed_cleavage_unit test passed");
    end else begin
      $display("protease_digest_missed_cleavage_unit test failed");
    end
    $finish;
  end

endmodule

>>> protease_digest_missed_cleavage_unit.f
rtl/core/pdmc_pkg.sv
rtl/core/pdmc_ctrl.sv
rtl/core/pdmc_dp.sv
rtl/core/protease_digest_missed_cleavage_unit.sv
rtl/core/pdmc_chk.sv
tb/testbench.sv
